FILE: sv/triangle_affine_map_setup_macros.svh
`ifndef TRIANGLE_AFFINE_MAP_SETUP_MACROS_SVH
`define TRIANGLE_AFFINE_MAP_SETUP_MACROS_SVH

// Condition must never hold outside reset.
`define TAMS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define TAMS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/tams_pkg.sv
package tams_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int RES_BITS       = 32;
  // quotient bits of 2*|num|*2^F/|det| kept before rounding
  localparam int QUOT_BITS      = 33;
  localparam int QUEUE_DEPTH    = 4;
  localparam int FRONT_LAT      = 4;
  localparam int DIV_LAT        = QUOT_BITS + 3;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: sv/tams_front.sv
module tams_front #(
  parameter int COORD_BITS = tams_pkg::COORD_BITS_DEF,
  parameter int DETW       = 2 * (COORD_BITS + 1) + 1,
  parameter int NUMW       = COORD_BITS + DETW + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] tex_x0,
  input  logic signed [COORD_BITS-1:0] tex_y0,
  input  logic signed [COORD_BITS-1:0] tex_x1,
  input  logic signed [COORD_BITS-1:0] tex_y1,
  input  logic signed [COORD_BITS-1:0] tex_x2,
  input  logic signed [COORD_BITS-1:0] tex_y2,
  input  logic signed [COORD_BITS-1:0] scr_x0,
  input  logic signed [COORD_BITS-1:0] scr_y0,
  input  logic signed [COORD_BITS-1:0] scr_x1,
  input  logic signed [COORD_BITS-1:0] scr_y1,
  input  logic signed [COORD_BITS-1:0] scr_x2,
  input  logic signed [COORD_BITS-1:0] scr_y2,
  output logic                         q_push,
  input  logic                         q_full,
  output logic signed [DETW-1:0]       det,
  output logic signed [DETW-1:0]       na,
  output logic signed [DETW-1:0]       nb,
  output logic signed [DETW-1:0]       nc,
  output logic signed [DETW-1:0]       nd,
  output logic signed [NUMW-1:0]       nu,
  output logic signed [NUMW-1:0]       nv
);
  import tams_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;

  logic [FRONT_LAT-1:0] vld;
  logic                 en;

  logic signed [DW-1:0] e1, f1, g1, h1, p1, q1, r1, s1;
  logic signed [CW-1:0] tx1r, ty1r, sx1r, sy1r;
  logic signed [DETW-1:0] det2, na2, nb2, nc2, nd2;
  logic signed [CW-1:0] tx2r, ty2r, sx2r, sy2r;
  logic signed [DETW-1:0] det3, na3, nb3, nc3, nd3;
  logic signed [NUMW-1:0] tu3, sa3, sb3, tv3, sc3, sd3;

  assign en     = !vld[FRONT_LAT-1] || !q_full;
  assign full   = !en;
  assign q_push = vld[FRONT_LAT-1] && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_LAT-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edge vectors
      e1 <= DW'(scr_x1) - DW'(scr_x0);
      f1 <= DW'(scr_x2) - DW'(scr_x0);
      g1 <= DW'(scr_y1) - DW'(scr_y0);
      h1 <= DW'(scr_y2) - DW'(scr_y0);
      p1 <= DW'(tex_x1) - DW'(tex_x0);
      q1 <= DW'(tex_x2) - DW'(tex_x0);
      r1 <= DW'(tex_y1) - DW'(tex_y0);
      s1 <= DW'(tex_y2) - DW'(tex_y0);
      tx1r <= tex_x0;
      ty1r <= tex_y0;
      sx1r <= scr_x0;
      sy1r <= scr_y0;

      det2 <= DETW'(e1) * DETW'(h1) - DETW'(f1) * DETW'(g1);
      na2  <= DETW'(p1) * DETW'(h1) - DETW'(q1) * DETW'(g1);
      nb2  <= DETW'(q1) * DETW'(e1) - DETW'(p1) * DETW'(f1);
      nc2  <= DETW'(r1) * DETW'(h1) - DETW'(s1) * DETW'(g1);
      nd2  <= DETW'(s1) * DETW'(e1) - DETW'(r1) * DETW'(f1);
      tx2r <= tx1r;
      ty2r <= ty1r;
      sx2r <= sx1r;
      sy2r <= sy1r;

      tu3  <= NUMW'(tx2r) * NUMW'(det2);
      sa3  <= NUMW'(sx2r) * NUMW'(na2);
      sb3  <= NUMW'(sy2r) * NUMW'(nb2);
      tv3  <= NUMW'(ty2r) * NUMW'(det2);
      sc3  <= NUMW'(sx2r) * NUMW'(nc2);
      sd3  <= NUMW'(sy2r) * NUMW'(nd2);
      det3 <= det2;
      na3  <= na2;
      nb3  <= nb2;
      nc3  <= nc2;
      nd3  <= nd2;

      nu  <= tu3 - sa3 - sb3;
      nv  <= tv3 - sc3 - sd3;
      det <= det3;
      na  <= na3;
      nb  <= nb3;
      nc  <= nc3;
      nd  <= nd3;
    end
  end

endmodule

FILE: sv/tams_queue.sv
`include "triangle_affine_map_setup_macros.svh"

module tams_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tams_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNTW-1:0]  count;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TAMS_ASSERT_IMPLY(a_no_overflow, push, !full || pop, "queue written while full")
  `TAMS_ASSERT_IMPLY(a_no_underflow, pop, !empty, "queue read while empty")
  `TAMS_ASSERT_NEVER(a_count_range, count > CNTW'(DEPTH), "queue count out of range")

endmodule

FILE: sv/tams_div.sv
module tams_div #(
  parameter int FRAC_BITS = tams_pkg::FRAC_BITS_DEF,
  parameter int DETW      = 29,
  parameter int NUMW      = 44
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [NUMW-1:0]             num,
  input  logic signed [DETW-1:0]             den,
  output logic signed [tams_pkg::RES_BITS-1:0] res
);
  import tams_pkg::*;

  localparam int QB = QUOT_BITS;
  localparam int RW = imax(NUMW + FRAC_BITS + 1, DETW + QB) + 1;

  logic [NUMW-1:0] nmag;
  logic [DETW-1:0] dmag_a;
  logic            neg_a;

  logic [RW-1:0]   rem_s [QB+1];
  logic [QB-1:0]   q_s   [QB+1];
  logic [DETW-1:0] d_s   [QB+1];
  logic            neg_s [QB+1];
  logic            ovf_s [QB+1];

  logic [QB:0]     q_inc;
  logic [QB-1:0]   mag;

  always_ff @(posedge clk) begin
    if (en) begin
      nmag   <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
      dmag_a <= den[DETW-1] ? DETW'(-den) : DETW'(den);
      neg_a  <= num[NUMW-1] ^ den[DETW-1];

      rem_s[0] <= RW'(nmag) << (FRAC_BITS + 1);
      ovf_s[0] <= (RW'(nmag) << (FRAC_BITS + 1)) >= (RW'(dmag_a) << QB);
      q_s[0]   <= '0;
      d_s[0]   <= dmag_a;
      neg_s[0] <= neg_a;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BIT = QB - 1 - k;
    logic [RW-1:0] sub;
    assign sub = RW'(d_s[k]) << BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_s[k] >= sub) begin
          rem_s[k+1] <= rem_s[k] - sub;
          q_s[k+1]   <= q_s[k] | (QB'(1) << BIT);
        end else begin
          rem_s[k+1] <= rem_s[k];
          q_s[k+1]   <= q_s[k];
        end
        d_s[k+1]   <= d_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  // round half away from zero: (2x + 1) >> 1
  assign q_inc = {1'b0, q_s[QB]} + 1'b1;
  assign mag   = q_inc[QB:1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_s[QB]) begin
        if (ovf_s[QB] || mag > QB'(64'h8000_0000)) begin
          res <= {1'b1, {(RES_BITS-1){1'b0}}};
        end else begin
          res <= RES_BITS'(-mag);
        end
      end else begin
        if (ovf_s[QB] || mag > QB'(64'h7FFF_FFFF)) begin
          res <= {1'b0, {(RES_BITS-1){1'b1}}};
        end else begin
          res <= RES_BITS'(mag);
        end
      end
    end
  end

endmodule

FILE: sv/tams_back.sv
`include "triangle_affine_map_setup_macros.svh"

module tams_back #(
  parameter int FRAC_BITS = tams_pkg::FRAC_BITS_DEF,
  parameter int DETW      = 29,
  parameter int NUMW      = 44
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic signed [DETW-1:0]               det,
  input  logic signed [DETW-1:0]               na,
  input  logic signed [DETW-1:0]               nb,
  input  logic signed [DETW-1:0]               nc,
  input  logic signed [DETW-1:0]               nd,
  input  logic signed [NUMW-1:0]               nu,
  input  logic signed [NUMW-1:0]               nv,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_a,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_b,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_c,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_d,
  output logic signed [tams_pkg::RES_BITS-1:0] shift_u,
  output logic signed [tams_pkg::RES_BITS-1:0] shift_v,
  output logic                                 degenerate
);
  import tams_pkg::*;

  logic [DIV_LAT-1:0] vld;
  logic [DIV_LAT-1:0] zr;
  logic               en;
  logic signed [NUMW-1:0] num [6];
  logic signed [RES_BITS-1:0] q [6];

  assign en    = !vld[DIV_LAT-1] || pop;
  assign q_pop = en && !q_empty;
  assign empty = !vld[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_LAT-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zr <= {zr[DIV_LAT-2:0], det == '0};
    end
  end

  assign num[0] = NUMW'(na);
  assign num[1] = NUMW'(nb);
  assign num[2] = NUMW'(nc);
  assign num[3] = NUMW'(nd);
  assign num[4] = nu;
  assign num[5] = nv;

  for (genvar i = 0; i < 6; i++) begin : g_lane
    tams_div #(
      .FRAC_BITS (FRAC_BITS),
      .DETW      (DETW),
      .NUMW      (NUMW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num[i]),
      .den (det),
      .res (q[i])
    );
  end

  // zero determinant: drop the quotients
  assign degenerate = zr[DIV_LAT-1];
  assign coef_a  = degenerate ? '0 : q[0];
  assign coef_b  = degenerate ? '0 : q[1];
  assign coef_c  = degenerate ? '0 : q[2];
  assign coef_d  = degenerate ? '0 : q[3];
  assign shift_u = degenerate ? '0 : q[4];
  assign shift_v = degenerate ? '0 : q[5];

  `TAMS_ASSERT_IMPLY(a_degen_zero, !empty && degenerate, coef_a == '0 && shift_v == '0, "degenerate item with nonzero result")
  `TAMS_ASSERT_IMPLY(a_stall_hold, $past(!empty && !pop && !rst), !empty, "waiting result lost")

endmodule

FILE: sv/triangle_affine_map_setup.sv
// Triangle-to-triangle affine map setup. Each item is a screen triangle and a
// texture triangle; the result is the 2x2 matrix (coef_a..coef_d) and the
// translation (shift_u, shift_v) that map screen to texture coordinates, in
// signed fixed point with FRAC_BITS fraction bits, rounded to nearest (ties
// away from zero) and saturated to 32 bits. A zero screen determinant gives
// degenerate = 1 and all-zero coefficients. One item is accepted per cycle
// while results are popped. Each item passes through 4 front-end stages
// (the first loads at the accepting edge), a 4-entry queue, and the 36
// stages of six parallel pipelined dividers (one quotient bit per stage).
// Stalls and items already waiting in the queue delay its result. full
// rises only when the queue and the front end are both backed up.
module triangle_affine_map_setup #(
  parameter int COORD_BITS = tams_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tams_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [COORD_BITS-1:0]         tex_x0,
  input  logic signed [COORD_BITS-1:0]         tex_y0,
  input  logic signed [COORD_BITS-1:0]         tex_x1,
  input  logic signed [COORD_BITS-1:0]         tex_y1,
  input  logic signed [COORD_BITS-1:0]         tex_x2,
  input  logic signed [COORD_BITS-1:0]         tex_y2,
  input  logic signed [COORD_BITS-1:0]         scr_x0,
  input  logic signed [COORD_BITS-1:0]         scr_y0,
  input  logic signed [COORD_BITS-1:0]         scr_x1,
  input  logic signed [COORD_BITS-1:0]         scr_y1,
  input  logic signed [COORD_BITS-1:0]         scr_x2,
  input  logic signed [COORD_BITS-1:0]         scr_y2,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_a,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_b,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_c,
  output logic signed [tams_pkg::RES_BITS-1:0] coef_d,
  output logic signed [tams_pkg::RES_BITS-1:0] shift_u,
  output logic signed [tams_pkg::RES_BITS-1:0] shift_v,
  output logic                                 degenerate
);
  import tams_pkg::*;

  localparam int DETW = 2 * (COORD_BITS + 1) + 1;
  localparam int NUMW = COORD_BITS + DETW + 2;
  localparam int QW   = 5 * DETW + 2 * NUMW;

  logic               f_push, q_full, q_empty, q_pop;
  logic [QW-1:0]      q_wr, q_rd;
  logic signed [DETW-1:0] f_det, f_na, f_nb, f_nc, f_nd;
  logic signed [NUMW-1:0] f_nu, f_nv;
  logic signed [DETW-1:0] b_det, b_na, b_nb, b_nc, b_nd;
  logic signed [NUMW-1:0] b_nu, b_nv;

  tams_front #(
    .COORD_BITS (COORD_BITS),
    .DETW       (DETW),
    .NUMW       (NUMW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .tex_x0 (tex_x0),
    .tex_y0 (tex_y0),
    .tex_x1 (tex_x1),
    .tex_y1 (tex_y1),
    .tex_x2 (tex_x2),
    .tex_y2 (tex_y2),
    .scr_x0 (scr_x0),
    .scr_y0 (scr_y0),
    .scr_x1 (scr_x1),
    .scr_y1 (scr_y1),
    .scr_x2 (scr_x2),
    .scr_y2 (scr_y2),
    .q_push (f_push),
    .q_full (q_full),
    .det    (f_det),
    .na     (f_na),
    .nb     (f_nb),
    .nc     (f_nc),
    .nd     (f_nd),
    .nu     (f_nu),
    .nv     (f_nv)
  );

  assign q_wr = {f_nv, f_nu, f_nd, f_nc, f_nb, f_na, f_det};

  tams_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .full    (q_full),
    .wr_data (q_wr),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  assign {b_nv, b_nu, b_nd, b_nc, b_nb, b_na, b_det} = q_rd;

  tams_back #(
    .FRAC_BITS (FRAC_BITS),
    .DETW      (DETW),
    .NUMW      (NUMW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .det        (b_det),
    .na         (b_na),
    .nb         (b_nb),
    .nc         (b_nc),
    .nd         (b_nd),
    .nu         (b_nu),
    .nv         (b_nv),
    .pop        (pop),
    .empty      (empty),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .coef_c     (coef_c),
    .coef_d     (coef_d),
    .shift_u    (shift_u),
    .shift_v    (shift_v),
    .degenerate (degenerate)
  );

endmodule

FILE: tb/triangle_affine_map_checker.sv
`timescale 1ns / 1ps

module triangle_affine_map_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [12:0] tex_x0, tex_y0, tex_x1, tex_y1, tex_x2, tex_y2,
  input  logic [12:0] scr_x0, scr_y0, scr_x1, scr_y1, scr_x2, scr_y2,
  input  logic        pop,
  input  logic        empty,
  input  logic [31:0] coef_a, coef_b, coef_c, coef_d, shift_u, shift_v,
  input  logic        degenerate,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] a, b, c, d, u, v;
    logic        dg;
  } map_t;

  map_t maps_due[$];

  // round(num * 2^16 / den) with ties away from zero, saturated to 32 bits
  function automatic logic [31:0] fixed_ratio(longint num, longint den);
    logic           neg;
    logic [63:0]    n, dd, q0, r0, fr, r1, mag;
    longint         res;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    dd = (den < 0) ? -den : den;
    q0 = n / dd;
    r0 = n % dd;
    if (q0 >= 64'h1_0000_0000) begin
      mag = 64'h100_0000_0000;
    end else begin
      fr = (r0 << 16) / dd;
      r1 = (r0 << 16) % dd;
      mag = (q0 << 16) + fr;
      if (2 * r1 >= dd) mag = mag + 1;
    end
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      res = -longint'(mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      res = longint'(mag);
    end
    return res[31:0];
  endfunction

  function automatic map_t affine_map(logic signed [12:0] tx0, ty0, tx1, ty1, tx2, ty2,
                                      sx0, sy0, sx1, sy1, sx2, sy2);
    map_t   m;
    longint e, f, g, h, p, q, r, s, det, na, nb, nc, nd, nu, nv;
    e = sx1 - sx0; f = sx2 - sx0; g = sy1 - sy0; h = sy2 - sy0;
    p = tx1 - tx0; q = tx2 - tx0; r = ty1 - ty0; s = ty2 - ty0;
    det = e * h - f * g;
    m = '0;
    if (det == 0) begin
      m.dg = 1'b1;
      return m;
    end
    na = p * h - q * g;
    nb = q * e - p * f;
    nc = r * h - s * g;
    nd = s * e - r * f;
    nu = longint'(tx0) * det - sx0 * na - sy0 * nb;
    nv = longint'(ty0) * det - sx0 * nc - sy0 * nd;
    m.a = fixed_ratio(na, det);
    m.b = fixed_ratio(nb, det);
    m.c = fixed_ratio(nc, det);
    m.d = fixed_ratio(nd, det);
    m.u = fixed_ratio(nu, det);
    m.v = fixed_ratio(nv, det);
    return m;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    map_t want;
    if (!rst) begin
      if (push && !full)
        maps_due.push_back(affine_map(tex_x0, tex_y0, tex_x1, tex_y1, tex_x2, tex_y2,
                                      scr_x0, scr_y0, scr_x1, scr_y1, scr_x2, scr_y2));
      if (pop && !empty) begin
        if (maps_due.size() == 0) begin
          errors++;
          $display("%0t result with nothing expected", $time);
        end else begin
          want = maps_due.pop_front();
          check_field("coef_a", want.a, coef_a);
          check_field("coef_b", want.b, coef_b);
          check_field("coef_c", want.c, coef_c);
          check_field("coef_d", want.d, coef_d);
          check_field("shift_u", want.u, shift_u);
          check_field("shift_v", want.v, shift_v);
          check_field("degenerate", {31'b0, want.dg}, {31'b0, degenerate});
        end
      end
    end
    pending = maps_due.size();
  end

endmodule

FILE: tb/triangle_affine_map_setup_test.sv
`timescale 1ns / 1ps

module triangle_affine_map_setup_test;

  logic        clk, rst, push, full, pop, empty, degenerate;
  logic [12:0] tx0, ty0, tx1, ty1, tx2, ty2, sx0, sy0, sx1, sy1, sx2, sy2;
  logic [31:0] coef_a, coef_b, coef_c, coef_d, shift_u, shift_v;
  int          errors, pending;
  logic        hold_pop;

  triangle_affine_map_setup u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .tex_x0(tx0), .tex_y0(ty0), .tex_x1(tx1), .tex_y1(ty1), .tex_x2(tx2), .tex_y2(ty2),
    .scr_x0(sx0), .scr_y0(sy0), .scr_x1(sx1), .scr_y1(sy1), .scr_x2(sx2), .scr_y2(sy2),
    .pop(pop), .empty(empty), .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .coef_d(coef_d), .shift_u(shift_u), .shift_v(shift_v), .degenerate(degenerate)
  );

  triangle_affine_map_checker u_check (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .tex_x0(tx0), .tex_y0(ty0), .tex_x1(tx1), .tex_y1(ty1), .tex_x2(tx2), .tex_y2(ty2),
    .scr_x0(sx0), .scr_y0(sy0), .scr_x1(sx1), .scr_y1(sy1), .scr_x2(sx2), .scr_y2(sy2),
    .pop(pop), .empty(empty), .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .coef_d(coef_d), .shift_u(shift_u), .shift_v(shift_v), .degenerate(degenerate),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [12:0] rand_coord(int mode);
    case (mode)
      0: return 13'h1000;
      1: return 13'h0FFF;
      2: return 13'($urandom_range(0, 16) - 8);
      default: return 13'($urandom);
    endcase
  endfunction

  // offer one item and hold it until accepted
  task automatic send_item(logic [12:0] c[12]);
    push <= 1'b1;
    {tx0, ty0, tx1, ty1, tx2, ty2} <= {c[0], c[1], c[2], c[3], c[4], c[5]};
    {sx0, sy0, sx1, sy1, sx2, sy2} <= {c[6], c[7], c[8], c[9], c[10], c[11]};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic idle(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  initial begin
    int pattern;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      pattern = $urandom_range(0, 15);
      if (hold_pop) pop <= 1'b0;
      else pop <= (pattern < 5) ? 1'b0 : 1'b1;
    end
  end

  initial begin
    logic [12:0] c[12];
    int mode, burst;
    rst = 1'b1;
    push = 1'b0;
    hold_pop = 1'b0;
    {tx0, ty0, tx1, ty1, tx2, ty2, sx0, sy0, sx1, sy1, sx2, sy2} = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, degenerate, unit map, large ratios
    for (int k = 0; k < 20; k++) begin
      foreach (c[j]) c[j] = rand_coord(k < 4 ? k : $urandom_range(0, 3));
      case (k)
        4: foreach (c[j]) c[j] = 13'h0;
        5: c = '{0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1};
        6: c = '{13'h1000, 13'h1000, 13'h0FFF, 13'h1000, 13'h1000, 13'h0FFF,
                 0, 0, 1, 0, 0, 1};
        7: c = '{0, 0, 13'h0FFF, 0, 0, 13'h0FFF, 13'h1000, 13'h1000,
                 13'h0FFF, 13'h0FFF, 13'h0FFF, 13'h1000};
        8: c = '{5, 3, 1, 2, 3, 4, 1, 1, 2, 2, 3, 3};
        9: c = '{0, 0, 1, 0, 0, 1, 0, 0, 2, 0, 0, 2};
        10: c = '{13'h1000, 13'h0FFF, 0, 0, 13'h0FFF, 13'h1000,
                  13'h0FFF, 0, 0, 13'h0FFF, 13'h1000, 13'h1000};
        default: ;
      endcase
      send_item(c);
    end
    idle(1);
    while (pending != 0) @(posedge clk);

    // long receiver hold-off so the block fills and stalls its input
    hold_pop = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk);
        hold_pop = 1'b0;
      end
      for (int k = 0; k < 80; k++) begin
        foreach (c[j]) c[j] = rand_coord(3);
        send_item(c);
      end
    join
    idle(1);
    while (pending != 0) @(posedge clk);

    for (int k = 0; k < 1450; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++, k++) begin
        mode = $urandom_range(0, 9);
        foreach (c[j]) c[j] = rand_coord(mode < 7 ? 3 : $urandom_range(0, 3));
        // collinear or coincident screen vertices
        if (mode == 9) begin
          c[10] = c[8]; c[11] = c[9];
        end
        send_item(c);
      end
      if ($urandom_range(0, 3) == 0) idle(1);
      else idle($urandom_range(1, 12));
    end
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
